// File: src/tilemap_expander_unit_defines.svh
// assertion macros shared by the tilemap expander rtl
// no dependencies; the using module provides clk and arst_n
`ifndef TILEMAP_EXPANDER_UNIT_DEFINES_SVH
`define TILEMAP_EXPANDER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TME_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tme assertion failed");
`define TME_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tme assertion failed");
`else
`define TME_ASSERT(lbl, prop)
`define TME_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/tme_pkg.sv
// constants, types and register codes of the tilemap expander
// no dependencies; used by tme_cfg_regs, tme_draw_seq and the top level
`default_nettype none
package tme_pkg;
	localparam int MAX_TILE_WIDTH  = 8;
	localparam int MAX_TILE_HEIGHT = 8;
	localparam int TILE_SLOTS      = 256;
	localparam int MAP_SIDE        = 1024;

	localparam int COL_W   = $clog2(MAX_TILE_WIDTH);
	localparam int ROW_W   = $clog2(MAX_TILE_HEIGHT);
	localparam int SLOT_W  = $clog2(TILE_SLOTS);
	localparam int ADDR_W  = SLOT_W + ROW_W + COL_W;
	localparam int DEPTH   = TILE_SLOTS * MAX_TILE_WIDTH * MAX_TILE_HEIGHT;
	localparam int SIZE_W  = 4;
	localparam int COUNT_W = 9;
	localparam int MAP_W   = 10;
	localparam int MAPC_W  = 13;
	localparam int COORD_W = 13;
	localparam int PROD_W  = MAP_W + SIZE_W;
	localparam int PIX_W   = 32;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	typedef enum logic [1:0] {
		REG_TILE_WIDTH  = 2'd0,
		REG_TILE_HEIGHT = 2'd1,
		REG_TILE_COUNT  = 2'd2
	} reg_idx_t;

	// tile size already clamped to 1..max
	typedef struct packed {
		logic [SIZE_W-1:0]  tile_w;
		logic [SIZE_W-1:0]  tile_h;
		logic [COUNT_W-1:0] tile_count;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [PIX_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;
endpackage
`default_nettype wire

// File: src/tme_tile_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module tme_tile_ram #(
	parameter int DEPTH  = 16384,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: src/tme_cfg_regs.sv
// apb register file: tile width, tile height, tile count
// depends on tme_pkg
`default_nettype none
module tme_cfg_regs
	import tme_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);
	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic [COUNT_W-1:0] count_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(MAX_TILE_WIDTH);
			height_q <= SIZE_W'(MAX_TILE_HEIGHT);
			count_q  <= COUNT_W'(TILE_SLOTS);
		end else if (wr_en) begin
			case (idx)
				REG_TILE_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_TILE_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				REG_TILE_COUNT:  count_q  <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TILE_WIDTH:  prdata = PDATA_W'(width_q);
			REG_TILE_HEIGHT: prdata = PDATA_W'(height_q);
			REG_TILE_COUNT:  prdata = PDATA_W'(count_q);
			default:         prdata = '0;
		endcase
	end

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (width_q == '0) begin
			cfg.tile_w = SIZE_W'(1);
		end else if (width_q > SIZE_W'(MAX_TILE_WIDTH)) begin
			cfg.tile_w = SIZE_W'(MAX_TILE_WIDTH);
		end else begin
			cfg.tile_w = width_q;
		end
		if (height_q == '0) begin
			cfg.tile_h = SIZE_W'(1);
		end else if (height_q > SIZE_W'(MAX_TILE_HEIGHT)) begin
			cfg.tile_h = SIZE_W'(MAX_TILE_HEIGHT);
		end else begin
			cfg.tile_h = height_q;
		end
		cfg.tile_count = count_q;
	end
endmodule
`default_nettype wire

// File: src/tme_draw_seq.sv
// item sequencer: load writes, draw read walk, read stage and output register
// depends on tme_pkg and the assertion macros header
`default_nettype none
`include "tilemap_expander_unit_defines.svh"
module tme_draw_seq
	import tme_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire logic [SLOT_W-1:0]  tile_number,
	input  wire logic [MAP_W-1:0]   map_x,
	input  wire logic [MAP_W-1:0]   map_y,
	input  wire logic [COL_W-1:0]   tile_col,
	input  wire logic [ROW_W-1:0]   tile_row,
	input  wire logic [PIX_W-1:0]   pixel_in,
	output ram_req_t                ram_req,
	input  wire logic [PIX_W-1:0]   ram_rdata,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [COORD_W-1:0] out_x,
	output logic      [COORD_W-1:0] out_y,
	output logic      [PIX_W-1:0]   pixel_out,
	output logic                    index_error,
	output logic                    last
);
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_state_t;

	seq_state_t         state_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SIZE_W-1:0]  w_q;
	logic [SIZE_W-1:0]  h_q;
	logic [COORD_W-1:0] ox_q;
	logic [COORD_W-1:0] oy_q;
	logic               err_q;
	logic [COL_W-1:0]   c_q;
	logic [ROW_W-1:0]   r_q;

	logic               v_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic               err_s1;
	logic               last_s1;

	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic [PIX_W-1:0]   pixel_q;
	logic               err_out_q;
	logic               last_out_q;

	logic               in_fire;
	logic               draw_go;
	logic               map_ok;
	logic               adv;
	logic               issue;
	logic               c_end;
	logic               r_end;
	logic               item_last;
	logic [PROD_W-1:0]  prod_x;
	logic [PROD_W-1:0]  prod_y;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign map_ok   = (MAPC_W'(map_x) < MAPC_W'(MAP_SIDE)) &&
	                  (MAPC_W'(map_y) < MAPC_W'(MAP_SIDE));
	assign draw_go  = in_fire && (mode == MODE_DRAW) && map_ok;
	assign prod_x   = PROD_W'(map_x) * PROD_W'(cfg.tile_w);
	assign prod_y   = PROD_W'(map_y) * PROD_W'(cfg.tile_h);

	// read stage moves on when the output register is free or drains
	assign adv       = v_s1 && (!out_valid_q || !out_stall);
	assign issue     = (state_q == ST_RUN) && (!v_s1 || adv);
	assign c_end     = (SIZE_W'(c_q) + SIZE_W'(1)) == w_q;
	assign r_end     = (SIZE_W'(r_q) + SIZE_W'(1)) == h_q;
	assign item_last = err_q || (c_end && r_end);

	always_comb begin
		ram_req.we    = in_fire && (mode == MODE_LOAD);
		ram_req.waddr = {tile_number, tile_row, tile_col};
		ram_req.wdata = pixel_in;
		ram_req.re    = issue && !err_q;
		ram_req.raddr = {slot_q, r_q, c_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			c_q     <= '0;
			r_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (draw_go) begin
						state_q <= ST_RUN;
						c_q     <= '0;
						r_q     <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (item_last) begin
							state_q <= ST_IDLE;
						end else if (c_end) begin
							c_q <= '0;
							r_q <= r_q + ROW_W'(1);
						end else begin
							c_q <= c_q + COL_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (draw_go) begin
			slot_q <= tile_number;
			w_q    <= cfg.tile_w;
			h_q    <= cfg.tile_h;
			ox_q   <= prod_x[COORD_W-1:0];
			oy_q   <= prod_y[COORD_W-1:0];
			err_q  <= {1'b0, tile_number} >= cfg.tile_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (issue) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			x_s1    <= ox_q + COORD_W'(c_q);
			y_s1    <= oy_q + COORD_W'(r_q);
			err_s1  <= err_q;
			last_s1 <= item_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q    <= x_s1;
			out_y_q    <= y_s1;
			pixel_q    <= err_s1 ? '0 : ram_rdata;
			err_out_q  <= err_s1;
			last_out_q <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign pixel_out   = pixel_q;
	assign index_error = err_out_q;
	assign last        = last_out_q;

	`TME_ASSERT(a_err_is_last, (out_valid_q && err_out_q) |-> last_out_q)
	`TME_ASSERT_NEXT(a_draw_starts, draw_go, state_q == ST_RUN)
	`TME_ASSERT_NEXT(a_last_ends_walk, issue && item_last, state_q == ST_IDLE)
	`TME_ASSERT_NEXT(a_s1_holds, v_s1 && out_valid_q && out_stall, v_s1)
endmodule
`default_nettype wire

// File: src/tilemap_expander_unit.sv
// top level of the tilemap expander: registers, sequencer and tile ram
// depends on tme_pkg, tme_cfg_regs, tme_draw_seq, tme_tile_ram
//
// channel  direction  handshake             payload
// cfg      in         apb psel/penable      paddr, pwdata, prdata
// in       in         in_valid / in_stall   mode .. pixel_in
// out      out        out_valid / out_stall out_x, out_y, pixel_out, index_error, last
//
// a load is written as it is taken; a draw stalls the input while it walks
// the w*h tile pixels (error draw: one step) on the one tile ram read port
// results leave one word per unstalled cycle behind a read stage and output register
// a stalled output backs up the read walk; loads enter once the walk is done
// reset clears control only; tile ram contents are undefined until loaded
`default_nettype none
module tilemap_expander_unit
	import tme_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire logic [SLOT_W-1:0]  tile_number,
	input  wire logic [MAP_W-1:0]   map_x,
	input  wire logic [MAP_W-1:0]   map_y,
	input  wire logic [COL_W-1:0]   tile_col,
	input  wire logic [ROW_W-1:0]   tile_row,
	input  wire logic [PIX_W-1:0]   pixel_in,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [COORD_W-1:0] out_x,
	output logic      [COORD_W-1:0] out_y,
	output logic      [PIX_W-1:0]   pixel_out,
	output logic                    index_error,
	output logic                    last
);
	cfg_t             cfg;
	ram_req_t         ram_req;
	logic [PIX_W-1:0] ram_rdata;

	tme_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tme_draw_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.tile_number (tile_number),
		.map_x       (map_x),
		.map_y       (map_y),
		.tile_col    (tile_col),
		.tile_row    (tile_row),
		.pixel_in    (pixel_in),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_x       (out_x),
		.out_y       (out_y),
		.pixel_out   (pixel_out),
		.index_error (index_error),
		.last        (last)
	);

	tme_tile_ram #(
		.DEPTH  (DEPTH),
		.WIDTH  (PIX_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);
endmodule
`default_nettype wire
